### hw/rtl/mfc_pkg.sv
package mfc_pkg;

    // Fields closed per reply before parsing stops
    localparam int MAX_FIELDS = 8;

    // Configuration register indexes
    localparam logic [1:0] CFG_CHECK_MODE = 2'd0;
    localparam logic [1:0] CFG_LIST_MODE  = 2'd1;
    localparam logic [1:0] CFG_START_CHAR = 2'd2;

    // Configuration reset values
    localparam logic [1:0] RST_CHECK_MODE = 2'd2;
    localparam logic       RST_LIST_MODE  = 1'b0;
    localparam logic [6:0] RST_START_CHAR = 7'h28;

    // Check modes
    localparam logic [1:0] CHK_SLASH = 2'd0;
    localparam logic [1:0] CHK_ACK   = 2'd1;

    // Verdict codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_FIRST = 2'd1;
    localparam logic [1:0] ST_BCC_BAD   = 2'd2;

    // Result kinds
    localparam logic KIND_VALUE   = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Characters (parity stripped)
    localparam logic [6:0] CH_NUL    = 7'h00;
    localparam logic [6:0] CH_ACK    = 7'h06;
    localparam logic [6:0] CH_CR     = 7'h0d;
    localparam logic [6:0] CH_RPAREN = 7'h29;
    localparam logic [6:0] CH_COMMA  = 7'h2c;
    localparam logic [6:0] CH_DOT    = 7'h2e;
    localparam logic [6:0] CH_SLASH  = 7'h2f;
    localparam logic [6:0] CH_ZERO   = 7'h30;
    localparam logic [6:0] CH_NINE   = 7'h39;

    // Fraction characters counted at most
    localparam logic [2:0] MAX_DECIMALS = 3'd4;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        logic        kind;
        logic [2:0]  field_index;
        logic [31:0] value;
        logic [2:0]  decimals;
        logic [1:0]  status;
        logic [3:0]  fields_found;
        logic        final_res;
    } t_res;

    // Results produced by one accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        t_res       r0;
        t_res       r1;
    } t_push;

    // Scale factor for a given decimal count
    function automatic logic [13:0] pow10(input logic [2:0] n);
        logic [13:0] p;
        case (n)
            3'd0:    p = 14'd1;
            3'd1:    p = 14'd10;
            3'd2:    p = 14'd100;
            3'd3:    p = 14'd1000;
            default: p = 14'd10000;
        endcase
        return p;
    endfunction

endpackage

### hw/rtl/meter_frame_checker_and_number_parser.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_ready  i_in  (rx_byte, last)
// result    out        o_valid / i_ready  o_out (kind .. final_res)
// config    in         i_cfg_we           i_cfg_idx, i_cfg_data
//
// One byte is taken per cycle while the input is ready; it yields zero, one or two results in the
// same cycle, written into a three-entry output queue.
// A byte that closes a field on the last byte gives two results; the
// result port hands them out in turn, one transfer per cycle while i_ready is high.
// The input is ready while the queue can hold two more results.
// Synchronous active-low reset clears parse state, configuration and queue.
module meter_frame_checker_and_number_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [6:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  mfc_pkg::t_in_item i_in,
    output logic              o_valid,
    input  logic              i_ready,
    output mfc_pkg::t_res     o_out
);
    import mfc_pkg::*;

    t_push push;
    logic  accept;

    assign accept = i_valid && o_ready;

    // Parse bytes and keep the block check
    mfc_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_in       (i_in),
        .o_push     (push)
    );

    // Hold results for the output channel
    mfc_out_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_in_ready (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

endmodule

### hw/rtl/mfc_parser.sv
module mfc_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [6:0]        i_cfg_data,
    input  logic              i_accept,
    input  mfc_pkg::t_in_item i_in,
    output mfc_pkg::t_push    o_push
);
    import mfc_pkg::*;

    typedef enum logic [3:0] {
        PH_SEEK = 4'b0001,
        PH_INT  = 4'b0010,
        PH_FRAC = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    logic [1:0]  r_check_mode;
    logic        r_list_mode;
    logic [6:0]  r_start_char;

    t_phase      r_phase,    n_phase;
    logic [31:0] r_int_acc,  n_int_acc;
    logic        r_int_open, n_int_open;
    logic [13:0] r_frac_acc, n_frac_acc;
    logic [2:0]  r_frac_cnt, n_frac_cnt;
    logic        r_frac_open, n_frac_open;
    logic [3:0]  r_fld_cnt,  n_fld_cnt;
    logic [6:0]  r_bcc,      n_bcc;
    logic [6:0]  r_first,    n_first;
    logic        r_seen,     n_seen;

    logic [6:0]  b;
    logic        is_last;
    logic        digit;
    logic [3:0]  digit_val;
    logic        close;
    logic [4:0]  fld_inc;
    logic [45:0] prod;
    logic [31:0] field_value;
    logic [6:0]  first_eff;
    logic [1:0]  status;
    t_res        res_val;
    t_res        res_vrd;

    assign b         = i_in.rx_byte[6:0];
    assign is_last   = i_in.last;
    assign digit     = b inside {[CH_ZERO:CH_NINE]};
    assign digit_val = 4'(b - CH_ZERO);
    assign fld_inc   = {1'b0, r_fld_cnt} + 5'd1;

    // Scale the integer run and add the fraction run
    assign prod        = r_int_acc * pow10(r_frac_cnt);
    assign field_value = prod[31:0] + {18'd0, r_frac_acc};

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= RST_CHECK_MODE;
            r_list_mode  <= RST_LIST_MODE;
            r_start_char <= RST_START_CHAR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHECK_MODE: r_check_mode <= i_cfg_data[1:0];
                CFG_LIST_MODE:  r_list_mode  <= i_cfg_data[0];
                CFG_START_CHAR: r_start_char <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Parse one byte and update the reply state
    always_comb begin
        n_phase     = r_phase;
        n_int_acc   = r_int_acc;
        n_int_open  = r_int_open;
        n_frac_acc  = r_frac_acc;
        n_frac_cnt  = r_frac_cnt;
        n_frac_open = r_frac_open;
        n_fld_cnt   = r_fld_cnt;
        n_bcc       = r_bcc;
        n_first     = r_first;
        n_seen      = r_seen;
        close       = 1'b0;

        case (r_phase)
            PH_SEEK: begin
                if (b == r_start_char) begin
                    n_int_acc   = '0;
                    n_int_open  = 1'b1;
                    n_frac_acc  = '0;
                    n_frac_cnt  = '0;
                    n_frac_open = 1'b1;
                    n_phase     = PH_INT;
                end else if (b == CH_NUL) begin
                    n_phase = PH_DONE;
                end
            end
            PH_INT, PH_FRAC: begin
                if (b == CH_RPAREN || (r_list_mode && b == CH_COMMA)) begin
                    close     = 1'b1;
                    n_fld_cnt = fld_inc[3:0];
                    if (b == CH_RPAREN || !r_list_mode || fld_inc >= 5'(MAX_FIELDS)) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_int_acc   = '0;
                        n_int_open  = 1'b1;
                        n_frac_acc  = '0;
                        n_frac_cnt  = '0;
                        n_frac_open = 1'b1;
                        n_phase     = PH_INT;
                    end
                end else if (b == CH_CR || b == CH_NUL) begin
                    n_phase = PH_DONE;
                end else if (r_phase == PH_INT) begin
                    if (b == CH_DOT) begin
                        n_int_open = 1'b0;
                        n_phase    = PH_FRAC;
                    end else if (r_int_open && digit) begin
                        n_int_acc = (r_int_acc << 3) + (r_int_acc << 1) + {28'd0, digit_val};
                    end else begin
                        n_int_open = 1'b0;
                    end
                end else if (r_frac_cnt < MAX_DECIMALS) begin
                    if (r_frac_open && digit) begin
                        n_frac_acc = (r_frac_acc << 3) + (r_frac_acc << 1)
                                   + {10'd0, digit_val};
                    end else begin
                        n_frac_open = 1'b0;
                    end
                    n_frac_cnt = r_frac_cnt + 3'd1;
                    if (n_frac_cnt >= MAX_DECIMALS) begin
                        n_frac_open = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        // Capture the first byte, fold the rest but the last into the block check
        if (!r_seen) begin
            n_first = b;
            n_seen  = 1'b1;
        end else if (!is_last) begin
            n_bcc = r_bcc ^ b;
        end

        // Clear everything at the end of a reply
        if (is_last) begin
            n_phase     = PH_SEEK;
            n_int_acc   = '0;
            n_int_open  = 1'b1;
            n_frac_acc  = '0;
            n_frac_cnt  = '0;
            n_frac_open = 1'b1;
            n_fld_cnt   = '0;
            n_bcc       = '0;
            n_first     = '0;
            n_seen      = 1'b0;
        end
    end

    // Form the verdict
    assign first_eff = r_seen ? r_first : b;

    always_comb begin
        case (r_check_mode)
            CHK_SLASH: status = (first_eff == CH_SLASH) ? ST_OK : ST_BAD_FIRST;
            CHK_ACK:   status = (first_eff == CH_ACK) ? ST_OK : ST_BAD_FIRST;
            default:   status = (r_bcc == b) ? ST_OK : ST_BCC_BAD;
        endcase
    end

    always_comb begin
        res_val.kind         = KIND_VALUE;
        res_val.field_index  = r_fld_cnt[2:0];
        res_val.value        = field_value;
        res_val.decimals     = r_frac_cnt;
        res_val.status       = ST_OK;
        res_val.fields_found = fld_inc[3:0];
        res_val.final_res    = !is_last;

        res_vrd.kind         = KIND_VERDICT;
        res_vrd.field_index  = '0;
        res_vrd.value        = '0;
        res_vrd.decimals     = '0;
        res_vrd.status       = status;
        res_vrd.fields_found = close ? fld_inc[3:0] : r_fld_cnt;
        res_vrd.final_res    = 1'b1;
    end

    // Hand the results of an accepted byte to the queue
    always_comb begin
        o_push.cnt = i_accept ? {1'b0, close} + {1'b0, is_last} : 2'd0;
        o_push.r0  = close ? res_val : res_vrd;
        o_push.r1  = res_vrd;
    end

    // Advance reply state on each transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SEEK;
            r_int_acc   <= '0;
            r_int_open  <= 1'b1;
            r_frac_acc  <= '0;
            r_frac_cnt  <= '0;
            r_frac_open <= 1'b1;
            r_fld_cnt   <= '0;
            r_bcc       <= '0;
            r_first     <= '0;
            r_seen      <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_int_acc   <= n_int_acc;
            r_int_open  <= n_int_open;
            r_frac_acc  <= n_frac_acc;
            r_frac_cnt  <= n_frac_cnt;
            r_frac_open <= n_frac_open;
            r_fld_cnt   <= n_fld_cnt;
            r_bcc       <= n_bcc;
            r_first     <= n_first;
            r_seen      <= n_seen;
        end
    end

endmodule

### hw/rtl/mfc_out_queue.sv
module mfc_out_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mfc_pkg::t_push i_push,
    output logic           o_in_ready,
    output logic           o_valid,
    input  logic           i_ready,
    output mfc_pkg::t_res  o_out
);
    import mfc_pkg::*;

    t_res       r_slot [0:2];
    t_res       n_slot [0:2];
    logic [1:0] r_cnt, n_cnt;
    logic       pop;
    logic [1:0] base;

    assign o_valid = (r_cnt != 2'd0);
    assign o_out   = r_slot[0];
    assign pop     = o_valid && i_ready;
    assign base    = r_cnt - {1'b0, pop};

    // Room for two more results after this cycle's transfer
    assign o_in_ready = (r_cnt <= 2'd1) || (r_cnt == 2'd2 && pop);

    // Shift on pop, fill behind the remaining entries
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_slot[i] = r_slot[i];
            if (pop && i < 2) begin
                n_slot[i] = r_slot[(i < 2) ? i + 1 : i];
            end
            if (i_push.cnt != 2'd0 && base == 2'(i)) begin
                n_slot[i] = i_push.r0;
            end else if (i_push.cnt == 2'd2 && base + 2'd1 == 2'(i)) begin
                n_slot[i] = i_push.r1;
            end
        end
        n_cnt = base + i_push.cnt;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r_slot[i] <= n_slot[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // Results arrive only on an accepted byte
    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_in_ready)
        else $error("results pushed while queue not ready");

    // A full queue takes no byte
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd3) |-> !o_in_ready)
        else $error("byte accepted into full queue");

    // A stalled head holds
    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_out == $past(o_out)))
        else $error("head result changed while stalled");

    // Occupancy tracks pushes and pops
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_cnt == $past(r_cnt - {1'b0, pop} + i_push.cnt)))
        else $error("queue count out of step");

endmodule

### verif/testbench.sv
module testbench;
    import mfc_pkg::*;

    localparam int QUIET_LIMIT  = 3000;
    localparam int STALL_LEN    = 200;
    localparam int DRAIN_CYCLES = 4;
    localparam int RANDOM_BYTES = 700;

    typedef enum logic [1:0] {SEEKING, IN_INTEGER, IN_FRACTION, PARSE_OFF} t_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [6:0]  i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    t_in_item    i_in;
    logic        o_valid;
    logic        i_ready;
    t_res        o_out;

    meter_frame_checker_and_number_parser uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in       (i_in),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out      (o_out)
    );

    // Parser mirror: configuration and per-reply state
    logic [1:0]  cfg_check;
    logic        cfg_list;
    logic [6:0]  cfg_start;
    t_phase      phase;
    logic [31:0] int_acc;
    logic        int_open;
    logic [13:0] frac_acc;
    logic [2:0]  frac_cnt;
    logic        frac_open;
    logic [3:0]  fields_closed;
    logic [6:0]  bcc_acc;
    logic [6:0]  first_byte;
    logic        have_first;

    t_res        expected_res[$];
    logic [7:0]  frame_buf[$];

    int          mismatch_count;
    int          quiet_cycles;
    int          bytes_sent;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          hold_req;
    logic [6:0]  cur_start;
    logic        cur_list;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic void open_field();
        int_acc   = '0;
        int_open  = 1'b1;
        frac_acc  = '0;
        frac_cnt  = '0;
        frac_open = 1'b1;
        phase     = IN_INTEGER;
    endfunction

    function automatic void clear_reply();
        open_field();
        phase         = SEEKING;
        fields_closed = '0;
        bcc_acc       = '0;
        first_byte    = '0;
        have_first    = 1'b0;
    endfunction

    // Work out the results of one accepted byte and queue them
    function automatic void predict_byte(input t_in_item it);
        logic [6:0]  ch;
        logic        fin;
        logic        is_digit;
        logic [31:0] v;
        logic [1:0]  verdict;
        ch       = it.rx_byte[6:0];
        fin      = it.last;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        case (phase)
            SEEKING: begin
                if (ch == cfg_start) open_field();
                else if (ch == CH_NUL) phase = PARSE_OFF;
            end
            IN_INTEGER, IN_FRACTION: begin
                if (ch == CH_RPAREN || (cfg_list && ch == CH_COMMA)) begin
                    v = int_acc;
                    for (int i = 0; i < int'(frac_cnt); i++) v = v * 32'd10;
                    v = v + 32'(frac_acc);
                    expected_res.push_back('{kind: KIND_VALUE,
                                             field_index: fields_closed[2:0],
                                             value: v, decimals: frac_cnt,
                                             status: ST_OK,
                                             fields_found: fields_closed + 4'd1,
                                             final_res: !fin});
                    fields_closed = fields_closed + 4'd1;
                    if (ch == CH_RPAREN || !cfg_list || int'(fields_closed) >= MAX_FIELDS)
                        phase = PARSE_OFF;
                    else
                        open_field();
                end else if (ch == CH_CR || ch == CH_NUL) begin
                    phase = PARSE_OFF;
                end else if (phase == IN_INTEGER) begin
                    if (ch == CH_DOT) begin
                        int_open = 1'b0;
                        phase    = IN_FRACTION;
                    end else if (int_open && is_digit) begin
                        int_acc = int_acc * 32'd10 + 32'(ch - CH_ZERO);
                    end else begin
                        int_open = 1'b0;
                    end
                end else if (frac_cnt < MAX_DECIMALS) begin
                    if (frac_open && is_digit)
                        frac_acc = frac_acc * 14'd10 + 14'(ch - CH_ZERO);
                    else
                        frac_open = 1'b0;
                    frac_cnt = frac_cnt + 3'd1;
                    if (frac_cnt >= MAX_DECIMALS) frac_open = 1'b0;
                end
            end
            default: ;
        endcase

        // Block check skips the first byte and the check byte itself
        if (!have_first) begin
            first_byte = ch;
            have_first = 1'b1;
        end else if (!fin) begin
            bcc_acc = bcc_acc ^ ch;
        end

        if (fin) begin
            if (cfg_check == CHK_SLASH)
                verdict = (first_byte == CH_SLASH) ? ST_OK : ST_BAD_FIRST;
            else if (cfg_check == CHK_ACK)
                verdict = (first_byte == CH_ACK) ? ST_OK : ST_BAD_FIRST;
            else
                verdict = (bcc_acc == ch) ? ST_OK : ST_BCC_BAD;
            expected_res.push_back('{kind: KIND_VERDICT, field_index: 3'd0, value: 32'd0,
                                     decimals: 3'd0, status: verdict,
                                     fields_found: fields_closed, final_res: 1'b1});
            clear_reply();
        end
    endfunction

    // Compare one result transfer against the oldest expectation
    function automatic void check_result(input t_res got);
        t_res want;
        if (expected_res.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected result: kind=%0d idx=%0d value=%0d dec=%0d st=%0d",
                         got.kind, got.field_index, got.value, got.decimals, got.status);
        end else begin
            want = expected_res.pop_front();
            if (got.kind !== want.kind || got.field_index !== want.field_index ||
                got.value !== want.value || got.decimals !== want.decimals ||
                got.status !== want.status || got.fields_found !== want.fields_found ||
                got.final_res !== want.final_res) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result mismatch: expected kind=%0d idx=%0d value=%0d dec=%0d ",
                             want.kind, want.field_index, want.value, want.decimals,
                             "st=%0d found=%0d fin=%0d, got kind=%0d idx=%0d value=%0d ",
                             want.status, want.fields_found, want.final_res,
                             got.kind, got.field_index, got.value,
                             "dec=%0d st=%0d found=%0d fin=%0d",
                             got.decimals, got.status, got.fields_found, got.final_res);
            end
        end
    endfunction

    // Track config writes, predict on input transfers, check output transfers
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHECK_MODE: cfg_check = i_cfg_data[1:0];
                    CFG_LIST_MODE:  cfg_list  = i_cfg_data[0];
                    CFG_START_CHAR: cfg_start = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) predict_byte(i_in);
            if (o_valid && i_ready) check_result(o_out);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial begin
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_ready <= 1'b0;
                repeat (STALL_LEN) @(posedge i_clk);
            end
            i_ready <= rx_idle_on ? ($urandom_range(0, 99) >= 10) : 1'b1;
        end
    end

    // Offer one byte; valid stays high across back-to-back transfers
    task automatic send_byte(input logic [7:0] b, input logic l);
        if (tx_idle_on && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in    <= '{rx_byte: b, last: l};
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    function automatic logic [7:0] with_parity(input logic [7:0] b);
        return {1'($urandom_range(0, 1)), b[6:0]};
    endfunction

    task automatic add_byte(input logic [7:0] b);
        frame_buf.push_back(b);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) frame_buf.push_back(s[i]);
    endtask

    // Send the buffered reply, then a last byte: the true check or a given one
    task automatic send_frame(input bit good_check, input logic [7:0] tail);
        logic [6:0] x;
        x = '0;
        for (int i = 0; i < frame_buf.size(); i++) begin
            if (i > 0) x = x ^ frame_buf[i][6:0];
            send_byte(with_parity(frame_buf[i]), 1'b0);
        end
        send_byte(good_check ? with_parity({1'b0, x}) : tail, 1'b1);
        frame_buf.delete();
    endtask

    // Drop valid and wait until every expected result has come out
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [1:0] chk, input logic lst, input logic [6:0] st);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CHECK_MODE;
        i_cfg_data <= {5'd0, chk};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_LIST_MODE;
        i_cfg_data <= {6'd0, lst};
        @(posedge i_clk);
        i_cfg_idx  <= CFG_START_CHAR;
        i_cfg_data <= st;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_start = st;
        cur_list  = lst;
    endtask

    // Random decimal field: integer run, optional fraction, rare junk
    task automatic add_number();
        int nd;
        nd = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
        repeat (nd) add_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) < 6) begin
            add_byte({1'b0, CH_DOT});
            repeat ($urandom_range(0, 6))
                add_byte(($urandom_range(0, 9) == 0) ? 8'h2a : 8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if ($urandom_range(0, 19) == 0) add_byte(8'($urandom_range(8'h41, 8'h5a)));
    endtask

    // Mostly well-formed replies with random content, some broken
    task automatic random_reply();
        int roll;
        int nf;
        int pos;
        roll = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0:       add_byte({1'b0, CH_ACK});
            1:       add_byte(8'($urandom_range(0, 127)));
            default: add_byte({1'b0, CH_SLASH});
        endcase
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(8'h41, 8'h5a)));
        add_byte({1'b0, cur_start});
        nf = cur_list ? $urandom_range(1, 10) : 1;
        for (int k = 0; k < nf; k++) begin
            add_number();
            add_byte({1'b0, (k == nf - 1) ? CH_RPAREN : CH_COMMA});
        end
        if (roll < 10) begin
            // corrupt one byte
            pos = $urandom_range(0, frame_buf.size() - 1);
            case ($urandom_range(0, 5))
                0:       frame_buf[pos] = {1'b0, CH_CR};
                1:       frame_buf[pos] = {1'b0, CH_NUL};
                2:       frame_buf[pos] = {1'b0, CH_RPAREN};
                3:       frame_buf[pos] = {1'b0, CH_COMMA};
                4:       frame_buf[pos] = {1'b0, CH_DOT};
                default: frame_buf[pos] = 8'($urandom_range(0, 255));
            endcase
        end else if (roll < 15) begin
            // truncate inside the reply
            pos = $urandom_range(0, frame_buf.size() - 1);
            while (frame_buf.size() > pos) void'(frame_buf.pop_back());
        end
        repeat ($urandom_range(0, 2))
            case ($urandom_range(0, 3))
                0:       add_byte({1'b0, CH_CR});
                1:       add_byte(8'h0a);
                2:       add_byte(8'h03);
                default: add_byte(8'h21);
            endcase
        send_frame(roll < 90, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_value_fields();
        add_str("/(12.34)");
        send_frame(1, 8'h00);
        add_str("(1.23456)");
        send_frame(1, 8'h00);
        add_str("(99999999999.9999)");
        send_frame(1, 8'h00);
        add_str("(1a2.3b4)");
        send_frame(1, 8'h00);
        add_str("(.5)");
        send_frame(1, 8'h00);
    endtask

    task automatic test_field_aborts();
        // NUL while seeking stops parsing for the reply
        add_byte({1'b0, CH_NUL});
        add_str("(5)");
        send_frame(1, 8'h00);
        // CR or NUL inside a field drops it
        add_str("(12");
        add_byte({1'b0, CH_CR});
        add_str("3)");
        send_frame(1, 8'h00);
        add_str("(12");
        add_byte({1'b0, CH_NUL});
        add_str(")");
        send_frame(1, 8'h00);
        // reply ends inside a field
        add_str("(123");
        send_frame(1, 8'h00);
        // last byte closes the field: value result then verdict
        add_str("(77");
        send_frame(0, 8'ha9);
        // single field mode stops after the first close
        add_str("(1)(2)");
        send_frame(1, 8'h00);
        // single byte replies
        send_frame(1, 8'h00);
        send_frame(0, 8'hab);
    endtask

    task automatic test_list_mode();
        set_config(RST_CHECK_MODE, 1'b1, RST_START_CHAR);
        add_str("(1,2.5,3)");
        send_frame(1, 8'h00);
        add_str("(1,2,3,4,5,6,7,8,9,10)");
        send_frame(1, 8'h00);
        add_str("(4,5");
        send_frame(0, {1'b0, CH_COMMA});
    endtask

    task automatic test_check_modes();
        for (int m = 0; m < 4; m++) begin
            set_config(2'(m), 1'b0, RST_START_CHAR);
            add_str("/(1)");
            send_frame(0, 8'h55);
            add_byte({1'b0, CH_ACK});
            add_str("(2)");
            send_frame(0, 8'h55);
            add_str("X(3)");
            send_frame(1, 8'h00);
        end
    endtask

    task automatic test_start_chars();
        set_config(RST_CHECK_MODE, 1'b0, 7'h5d);
        add_str("/]7)");
        send_frame(1, 8'h00);
        set_config(RST_CHECK_MODE, 1'b1, 7'h00);
        add_byte({1'b0, CH_SLASH});
        add_byte({1'b0, CH_NUL});
        add_str("4,6)");
        send_frame(1, 8'h00);
        set_config(RST_CHECK_MODE, 1'b0, 7'h7f);
        add_byte({1'b0, CH_SLASH});
        add_byte(8'hff);
        add_str("9)");
        send_frame(1, 8'h00);
    endtask

    // Hold the result side off while full lists keep coming in
    task automatic test_output_stall();
        set_config(RST_CHECK_MODE, 1'b1, RST_START_CHAR);
        hold_req = 1'b1;
        repeat (3) begin
            add_str("/(1,22,333,4.4,5,6,7,8)");
            send_frame(1, 8'h00);
        end
    endtask

    task automatic test_random_traffic();
        int start_count;
        int cfg_mark;
        logic [6:0] st;
        start_count = bytes_sent;
        cfg_mark    = bytes_sent;
        while (bytes_sent - start_count < RANDOM_BYTES) begin
            // stretch with no idling on either side
            tx_idle_on = !((bytes_sent - start_count) inside {[300:500]});
            rx_idle_on = tx_idle_on;
            if (bytes_sent - cfg_mark >= 200) begin
                case ($urandom_range(0, 5))
                    0:       st = 7'h5d;
                    1:       st = 7'($urandom_range(0, 127));
                    default: st = RST_START_CHAR;
                endcase
                set_config(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), st);
                cfg_mark = bytes_sent;
            end
            random_reply();
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_CHECK_MODE;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_in       <= '0;
        cfg_check  = RST_CHECK_MODE;
        cfg_list   = RST_LIST_MODE;
        cfg_start  = RST_START_CHAR;
        cur_start  = RST_START_CHAR;
        cur_list   = RST_LIST_MODE;
        clear_reply();
        mismatch_count = 0;
        bytes_sent     = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        hold_req       = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_value_fields();
        test_field_aborts();
        test_list_mode();
        test_check_modes();
        test_start_chars();
        test_output_stall();
        set_config(RST_CHECK_MODE, RST_LIST_MODE, RST_START_CHAR);
        test_random_traffic();

        wait_idle();
        if (mismatch_count == 0 && expected_res.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/mfc_pkg.sv
hw/rtl/mfc_parser.sv
hw/rtl/mfc_out_queue.sv
hw/rtl/meter_frame_checker_and_number_parser.sv
verif/testbench.sv
